[rtl/xce_pkg.sv]
// Shared types, character codes and the character lookup for the XML character escaper.
package xce_pkg;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] LOW_LIMIT  = 8'd32;
	localparam logic [7:0] HIGH_LIMIT = 8'd127;

	// Entity texts, first character at index 0, unused top slots zero.
	localparam logic [5:0][7:0] ENT_AMP  = {8'h00, ";", "p", "m", "a", "&"};
	localparam logic [5:0][7:0] ENT_LT   = {8'h00, 8'h00, ";", "t", "l", "&"};
	localparam logic [5:0][7:0] ENT_GT   = {8'h00, 8'h00, ";", "t", "g", "&"};
	localparam logic [5:0][7:0] ENT_QUOT = {";", "t", "o", "u", "q", "&"};
	localparam logic [5:0][7:0] ENT_APOS = {";", "s", "o", "p", "a", "&"};

	typedef enum logic [2:0] {
		KIND_PASS,
		KIND_AMP,
		KIND_LT,
		KIND_GT,
		KIND_QUOT,
		KIND_APOS,
		KIND_NUM
	} kind_t;

	// One classified word: how to expand it and how many characters it yields.
	typedef struct packed {
		logic [7:0]      raw;
		kind_t           kind;
		logic [2:0]      len;
		logic [2:0][3:0] digits;
	} desc_t;

	function automatic logic [7:0] esc_char(desc_t d, logic [2:0] idx);
		logic [5:0][7:0] ent;
		logic [2:0]      doff;
		logic [7:0]      ch;
		ent  = '0;
		doff = idx - 3'd2;
		ch   = d.raw;
		unique case (d.kind)
			KIND_AMP:  ent = ENT_AMP;
			KIND_LT:   ent = ENT_LT;
			KIND_GT:   ent = ENT_GT;
			KIND_QUOT: ent = ENT_QUOT;
			KIND_APOS: ent = ENT_APOS;
			default:   ent = '0;
		endcase
		unique case (d.kind)
			KIND_PASS: ch = d.raw;
			KIND_NUM: begin
				if (idx == 3'd0) begin
					ch = CH_AMP;
				end else if (idx == 3'd1) begin
					ch = CH_HASH;
				end else if (idx == d.len - 3'd1) begin
					ch = CH_SEMI;
				end else begin
					ch = {4'h3, d.digits[doff[1:0]]};
				end
			end
			KIND_AMP, KIND_LT, KIND_GT, KIND_QUOT, KIND_APOS: ch = ent[idx];
			default: ch = d.raw;
		endcase
		return ch;
	endfunction

endpackage

[rtl/xml_character_escaper_top.sv]
// Top level of the XML character escaper: front end, word queue and expander.
//
// Input channel: a raw byte is written with push while full is low. Output channel:
// while empty is low, out_char and is_last show the oldest waiting character, and
// pop takes it. Each byte yields one to six characters, is_last marking the final one.
// A written byte passes the word queue and then the output register before its first
// character shows. Throughput: one character per cycle while pop is high. A byte that
// passes through unchanged yields one character, so such bytes stream at one per cycle;
// an entity or a numeric reference holds the expander for its four to six characters.
// The front end classifies bytes into a QUEUE_DEPTH-word queue (2 to 16), so input
// keeps flowing while the expander works or the receiver stalls; full rises only
// when that queue is full. When pop stays low the shown character holds.
// Reset empties the queue and the output register: empty is high and full is low.
module xml_character_escaper_top import xce_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       is_last
);

	desc_t front_desc;
	desc_t head_desc;
	logic  head_valid;
	logic  deq;
	logic  accept;

	assign accept = push && !full;

	xce_front u_front (
		.in_byte (in_byte),
		.desc    (front_desc)
	);

	xce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_desc  (front_desc),
		.full     (full),
		.rd_en    (deq),
		.rd_desc  (head_desc),
		.rd_valid (head_valid)
	);

	xce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_desc),
		.head_valid (head_valid),
		.deq        (deq),
		.empty      (empty),
		.pop        (pop),
		.out_char   (out_char),
		.is_last    (is_last)
	);

endmodule

[rtl/xce_front.sv]
// Front end: classifies a raw byte and works out its decimal digits and expansion length.
module xce_front import xce_pkg::*; (
	input  logic [7:0] in_byte,
	output desc_t      desc
);

	logic [1:0]  hund;
	logic [7:0]  rem;
	logic [14:0] prod;
	logic [3:0]  tens;
	logic [3:0]  ones;
	logic        is_num;

	always_comb begin
		if (in_byte >= 8'd200) begin
			hund = 2'd2;
		end else if (in_byte >= 8'd100) begin
			hund = 2'd1;
		end else begin
			hund = 2'd0;
		end
	end

	// The remainder stays below 100, so times 205 shifted by 11 is an exact divide by ten.
	assign rem    = in_byte - 8'(hund) * 8'd100;
	assign prod   = 15'(rem[6:0]) * 15'd205;
	assign tens   = prod[14:11];
	assign ones   = 4'(rem - 8'(tens) * 8'd10);
	assign is_num = (in_byte < LOW_LIMIT) || (in_byte > HIGH_LIMIT);

	always_comb begin
		desc.raw    = in_byte;
		desc.kind   = KIND_PASS;
		desc.len    = 3'd1;
		desc.digits = '0;
		unique case (in_byte)
			CH_AMP: begin
				desc.kind = KIND_AMP;
				desc.len  = 3'd5;
			end
			CH_LT: begin
				desc.kind = KIND_LT;
				desc.len  = 3'd4;
			end
			CH_GT: begin
				desc.kind = KIND_GT;
				desc.len  = 3'd4;
			end
			CH_QUOT: begin
				desc.kind = KIND_QUOT;
				desc.len  = 3'd6;
			end
			CH_APOS: begin
				desc.kind = KIND_APOS;
				desc.len  = 3'd6;
			end
			default: begin
				if (is_num) begin
					desc.kind = KIND_NUM;
					// Digits are packed from index 0 so leading zeros never appear.
					if (hund != 2'd0) begin
						desc.len    = 3'd6;
						desc.digits = {ones, tens, {2'b00, hund}};
					end else if (tens != 4'd0) begin
						desc.len    = 3'd5;
						desc.digits = {4'd0, ones, tens};
					end else begin
						desc.len    = 3'd4;
						desc.digits = {4'd0, 4'd0, ones};
					end
				end
			end
		endcase
	end

endmodule

[rtl/xce_queue.sv]
// Short queue of classified words between the front end and the expander.
module xce_queue import xce_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  desc_t wr_desc,
	output logic  full,
	input  logic  rd_en,
	output desc_t rd_desc,
	output logic  rd_valid
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t             entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/xce_back.sv]
// Back end: walks the head word character by character into the output register.
module xce_back import xce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  desc_t      head,
	input  logic       head_valid,
	output logic       deq,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       is_last
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       is_last_q;
	logic       take;
	logic       at_end;

	// A new character moves in when the output register is free or being emptied.
	assign take   = head_valid && (!out_valid_q || pop);
	assign at_end = (idx_q == head.len - 3'd1);
	assign deq    = take && at_end;

	assign empty    = !out_valid_q;
	assign out_char = out_char_q;
	assign is_last  = is_last_q;

	always_ff @(posedge clk) begin
		if (take) begin
			out_char_q <= esc_char(head, idx_q);
			is_last_q  <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? 3'd0 : idx_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/xce_checker.sv]
// Port-level checker for the XML character escaper and its bind to the top level.
module xce_checker import xce_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_char,
	input logic       is_last
);

	// Reset leaves both sides clear.
	assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("reset did not clear the queues");

	// A waiting character holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_char) && $stable(is_last)))
		else $error("stalled output changed");

	// An ampersand always opens an escape and is never the final character.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_char == CH_AMP) |-> !is_last)
		else $error("ampersand marked last");

	// Characters inside an escape are the ampersand, hash, digits or lower-case letters.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_last) |-> (out_char == CH_AMP || out_char == CH_HASH ||
			(out_char >= 8'h30 && out_char <= 8'h39) ||
			(out_char >= 8'h61 && out_char <= 8'h7A)))
		else $error("unexpected character inside an escape");

endmodule

bind xml_character_escaper_top xce_checker u_xce_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_char (out_char),
	.is_last  (is_last)
);

[bench/xml_character_escaper_top_tb.sv]
// Self-checking testbench for the XML character escaper top level.
module xml_character_escaper_top_tb;
	import xce_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} esc_word_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] in_byte;
	logic       empty;
	logic       pop;
	logic [7:0] out_char;
	logic       is_last;

	esc_word_t expected_chars[$];
	esc_word_t head;
	int        bytes_sent;
	int        chars_checked;
	int        full_cycles;
	int        fail_count;
	bit        send_gaps;
	bit        recv_gaps;
	bit        hold_request;

	xml_character_escaper_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_byte(in_byte),
		.empty(empty),
		.pop(pop),
		.out_char(out_char),
		.is_last(is_last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Appends the escaped text of one source byte to the expected characters.
	function automatic void expect_escaped(logic [7:0] b);
		string txt;
		case (b)
			CH_AMP:  txt = "&amp;";
			CH_LT:   txt = "&lt;";
			CH_GT:   txt = "&gt;";
			CH_QUOT: txt = "&quot;";
			CH_APOS: txt = "&apos;";
			default: begin
				if (b < LOW_LIMIT || b > HIGH_LIMIT) begin
					txt = $sformatf("&#%0d;", b);
				end else begin
					txt = $sformatf("%c", b);
				end
			end
		endcase
		for (int i = 0; i < txt.len(); i++) begin
			expected_chars.push_back(esc_word_t'{ch: txt[i], last: (i == txt.len() - 1)});
		end
	endfunction

	function automatic logic [7:0] random_byte();
		logic [7:0] specials[5];
		specials = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'($urandom_range(32, 126));
			4, 5:       return specials[$urandom_range(0, 4)];
			6, 7:       return 8'($urandom_range(0, 31));
			default:    return 8'($urandom_range(127, 255));
		endcase
	endfunction

	// Checks each popped word against the oldest expectation and predicts on each push.
	always @(posedge clk) begin
		if (pop && !empty) begin
			chars_checked++;
			if (expected_chars.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%t: unexpected word char=%h last=%b", $realtime, out_char, is_last);
				end
			end else begin
				head = expected_chars.pop_front();
				if (out_char !== head.ch || is_last !== head.last) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%t: mismatch expected char=%h last=%b, got char=%h last=%b",
							$realtime, head.ch, head.last, out_char, is_last);
					end
				end
			end
		end
		if (push && !full) begin
			bytes_sent++;
			expect_escaped(in_byte);
		end
		if (full) begin
			full_cycles++;
		end
	end

	// Receiver: random pop bursts, plus one long hold-off when a test asks for it.
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				pop <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					@(posedge clk);
				end
			end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offers one byte and returns at the edge where it is taken; push stays high
	// unless a gap follows, so back-to-back words never toggle it within one step.
	task automatic send_byte(input logic [7:0] b);
		in_byte <= b;
		push    <= 1'b1;
		do @(posedge clk); while (full !== 1'b0);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// The first edge lets the monitor record the last accepted byte before the check.
	task automatic wait_drain();
		push <= 1'b0;
		@(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_directed();
		logic [7:0] picks[$];
		picks = '{8'd0, 8'd1, 8'd9, 8'd10, 8'd31, 8'd32, 8'd99, 8'd100, 8'd126, 8'd127,
			8'd128, 8'd199, 8'd200, 8'd255, CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS,
			CH_HASH, CH_SEMI, "A", "z", "0"};
		foreach (picks[i]) begin
			send_byte(picks[i]);
		end
		wait_drain();
	endtask

	// The receiver stops long enough for the word queue to fill and push to stall.
	task automatic test_backpressure();
		send_gaps    = 1'b0;
		hold_request = 1'b1;
		repeat (24) send_byte(random_byte());
		wait_drain();
		send_gaps = 1'b1;
	endtask

	task automatic test_random();
		repeat (140) send_byte(random_byte());
		wait_drain();
	endtask

	task automatic test_streaming();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		repeat (40) send_byte(random_byte());
		wait_drain();
	endtask

	initial begin
		bytes_sent    = 0;
		chars_checked = 0;
		full_cycles   = 0;
		fail_count    = 0;
		send_gaps     = 1'b1;
		recv_gaps     = 1'b1;
		hold_request  = 1'b0;
		push    <= 1'b0;
		in_byte <= 8'h00;
		arst_n  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random();
		test_streaming();

		if (expected_chars.size() != 0) begin
			fail_count++;
			$display("%0d expected characters never came out.", expected_chars.size());
		end

		$display("Escaped %0d bytes into %0d checked characters (entities, numeric refs, pass-through).",
			bytes_sent, chars_checked);
		$display("Input was held off by a full queue for %0d cycles; %0d mismatches.",
			full_cycles, fail_count);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
